### rtl/sctm_pkg.sv
// ----------------------------------------------------------------------------
// sctm_pkg
// Shared types and constants of the sprite column texel mapper: beat
// structs of both channels, command codes and configuration register codes.
// ----------------------------------------------------------------------------
package sctm_pkg;

    // default geometry
    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 768;
    localparam int TEX_WORDS_DEF     = 4096;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_DEPTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR     = 3'd6;

    // commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // fixed field widths
    localparam int SPR_W     = 13;
    localparam int TEX_DIM_W = 7;
    localparam int COLOR_W   = 24;
    localparam int DEPTH_W   = 16;
    localparam int LIN_W     = 2 * TEX_DIM_W;
    localparam int QUO_W     = TEX_DIM_W + 1;
    localparam int NUMX_W    = 20;
    localparam int NUMY_W    = 21;

    typedef struct packed {
        logic               command;
        logic [11:0]        texel_address;
        logic [23:0]        texel_value;
        logic signed [11:0] column;
        logic [9:0]         row;
        logic signed [15:0] column_depth;
    } in_beat_t;

    typedef struct packed {
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
        logic [23:0] pixel_color;
    } out_beat_t;

endpackage

### rtl/sctm_ram.sv
// ----------------------------------------------------------------------------
// sctm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while the read enable is low.
// ----------------------------------------------------------------------------
module sctm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sctm_div_pipe.sv
// ----------------------------------------------------------------------------
// sctm_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The quotient
// saturates to all ones when it does not fit in Q_W bits. The divisor is
// a static configuration value and is not pipelined.
// ----------------------------------------------------------------------------
module sctm_div_pipe #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 13,
    parameter int Q_W   = 8
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    localparam int CW = DEN_W + Q_W;

    logic [NUM_W-1:0] rem_reg [Q_W-1];
    logic [Q_W-1:0]   q_reg   [Q_W];
    logic             sat_reg [Q_W];

    logic [NUM_W-1:0] rem_in  [Q_W];
    logic [Q_W-1:0]   q_in    [Q_W];
    logic             sat_in  [Q_W];
    logic             take    [Q_W];
    logic [CW-1:0]    trial   [Q_W];
    logic [NUM_W-1:0] rem_next [Q_W-1];
    logic [Q_W-1:0]   q_next  [Q_W];
    logic [CW-1:0]    den_w;

    assign den_w = CW'(den);

    always_comb begin
        rem_in[0] = num;
        q_in[0]   = '0;
        sat_in[0] = CW'(num) >= (den_w << Q_W);
        for (int i = 1; i < Q_W; i++) begin
            rem_in[i] = rem_reg[i-1];
            q_in[i]   = q_reg[i-1];
            sat_in[i] = sat_reg[i-1];
        end
        for (int i = 0; i < Q_W; i++) begin
            trial[i]  = den_w << (Q_W - 1 - i);
            take[i]   = CW'(rem_in[i]) >= trial[i];
            q_next[i] = q_in[i] | (take[i] ? (Q_W'(1) << (Q_W - 1 - i)) : '0);
        end
        for (int i = 0; i < Q_W - 1; i++) begin
            rem_next[i] = take[i] ? NUM_W'(CW'(rem_in[i]) - trial[i]) : rem_in[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < Q_W; i++) begin
                q_reg[i]   <= q_next[i];
                sat_reg[i] <= sat_in[i];
            end
            for (int i = 0; i < Q_W - 1; i++) begin
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    assign quo = sat_reg[Q_W-1] ? '1 : q_reg[Q_W-1];

endmodule

### rtl/sprite_column_texel_mapper_top.sv
// ----------------------------------------------------------------------------
// sprite_column_texel_mapper_top
// Sprite texture mapper for a raycaster: loads texels into a row-major
// texture store and maps draw beats to textured, depth-tested pixels.
//
// Usage:
//   cfg_we/cfg_index/cfg_wdata write the sprite and texture registers; write
//   them only while no beat is in flight.
//   s_ channel: a load beat writes one texel, a draw beat names one pixel.
//   m_ channel: one beat per drawn, visible, non-transparent pixel; loads
//   and rejected pixels give no beat.
//   Throughput: one beat per cycle while s_ready is high, set by the pipeline of
//   one-bit divider stages and the simple dual-port texture store, read at the
//   memory stage beside its write port.
//   Stall: the output register and one skid entry hold results; s_ready
//   drops only when the skid entry is full, and then the whole pipeline
//   freezes in place until m_ready takes the waiting beat.
//   Reset: registers return to sprite size 1x1, left 0, depth 0, texture
//   64x64, key color 0; the pipeline empties. Texture contents are not
//   cleared and must be loaded before they are drawn.
// ----------------------------------------------------------------------------
module sprite_column_texel_mapper_top #(
    parameter int SCREEN_WIDTH  = sctm_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = sctm_pkg::SCREEN_HEIGHT_DEF,
    parameter int TEX_WORDS     = sctm_pkg::TEX_WORDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sctm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sctm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sctm_pkg::in_beat_t             s_beat,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sctm_pkg::out_beat_t            m_beat
);

    import sctm_pkg::*;

    localparam int ADDR_W    = $clog2(TEX_WORDS);
    localparam int MOD_STEPS = LIN_W - ADDR_W + 1;
    localparam int MOD_W     = LIN_W + 1;
    localparam int DIV_LAT   = QUO_W;

    typedef struct packed {
        logic         valid;
        logic         load;
        logic         draw;
        logic [9:0]   px;
        logic [9:0]   py;
        logic [11:0]  taddr;
        logic [23:0]  tval;
    } side_t;

    // configuration registers
    logic [SPR_W-1:0]         sh_reg;
    logic [SPR_W-1:0]         sw_reg;
    logic signed [SPR_W-1:0]  left_reg;
    logic signed [DEPTH_W-1:0] depth_reg;
    logic [TEX_DIM_W-1:0]     tw_reg;
    logic [TEX_DIM_W-1:0]     th_reg;
    logic [COLOR_W-1:0]       key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sh_reg    <= SPR_W'(1);
            sw_reg    <= SPR_W'(1);
            left_reg  <= '0;
            depth_reg <= '0;
            tw_reg    <= TEX_DIM_W'(64);
            th_reg    <= TEX_DIM_W'(64);
            key_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SPRITE_HEIGHT: begin
                    sh_reg <= (cfg_wdata[SPR_W-1:0] == '0) ? SPR_W'(1) : cfg_wdata[SPR_W-1:0];
                end
                CFG_SPRITE_WIDTH: begin
                    sw_reg <= (cfg_wdata[SPR_W-1:0] == '0) ? SPR_W'(1) : cfg_wdata[SPR_W-1:0];
                end
                CFG_SPRITE_LEFT: begin
                    left_reg <= $signed(cfg_wdata[SPR_W-1:0]);
                end
                CFG_SPRITE_DEPTH: begin
                    depth_reg <= $signed(cfg_wdata[DEPTH_W-1:0]);
                end
                CFG_TEX_WIDTH: begin
                    tw_reg <= (cfg_wdata[TEX_DIM_W-1:0] == '0) ? TEX_DIM_W'(1)
                                                              : cfg_wdata[TEX_DIM_W-1:0];
                end
                CFG_TEX_HEIGHT: begin
                    th_reg <= (cfg_wdata[TEX_DIM_W-1:0] == '0) ? TEX_DIM_W'(1)
                                                              : cfg_wdata[TEX_DIM_W-1:0];
                end
                CFG_KEY_COLOR: begin
                    key_reg <= cfg_wdata[COLOR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline enable: frozen only while the skid entry is full
    logic en;
    logic skid_valid_reg;
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // stage 1: screen and depth tests, numerators of both divisions
    logic              on_screen;
    logic              depth_ok;
    logic signed [13:0] dx;
    logic signed [14:0] ey;
    logic signed [21:0] s1_nx_next;
    logic signed [22:0] s1_ny_next;
    side_t             s1_next;

    always_comb begin
        on_screen = !s_beat.column[11]
                 && ({1'b0, s_beat.column} < 13'(SCREEN_WIDTH))
                 && ({1'b0, s_beat.row} < 11'(SCREEN_HEIGHT));
        depth_ok  = (depth_reg > 16'sd0) && (depth_reg < s_beat.column_depth);
        dx = $signed({{2{s_beat.column[11]}}, s_beat.column})
           - $signed({left_reg[SPR_W-1], left_reg});
        ey = $signed({4'b0, s_beat.row, 1'b0}) - $signed(15'(SCREEN_HEIGHT))
           + $signed({2'b0, sh_reg});
        s1_nx_next = dx * $signed({1'b0, tw_reg});
        s1_ny_next = ey * $signed({1'b0, th_reg});

        s1_next.valid = s_valid;
        s1_next.load  = s_valid && (s_beat.command == CMD_LOAD)
                     && ({1'b0, s_beat.texel_address} < 13'(TEX_WORDS));
        s1_next.draw  = s_valid && (s_beat.command == CMD_DRAW) && on_screen && depth_ok;
        s1_next.px    = s_beat.column[9:0];
        s1_next.py    = s_beat.row;
        s1_next.taddr = s_beat.texel_address;
        s1_next.tval  = s_beat.texel_value;
    end

    side_t              s1_reg;
    logic signed [21:0] s1_nx_reg;
    logic signed [22:0] s1_ny_reg;

    // dividers: texture column and row
    logic [NUMX_W-1:0] num_x;
    logic [NUMY_W-1:0] num_y;
    logic [QUO_W-1:0]  qx;
    logic [QUO_W-1:0]  qy;

    assign num_x = s1_nx_reg[21] ? '0 : s1_nx_reg[NUMX_W-1:0];
    assign num_y = s1_ny_reg[22] ? '0 : s1_ny_reg[NUMY_W-1:0];

    sctm_div_pipe #(
        .NUM_W (NUMX_W),
        .DEN_W (SPR_W),
        .Q_W   (QUO_W)
    ) u_div_x (
        .aclk (aclk),
        .en   (en),
        .num  (num_x),
        .den  (sw_reg),
        .quo  (qx)
    );

    sctm_div_pipe #(
        .NUM_W (NUMY_W),
        .DEN_W (SPR_W + 1),
        .Q_W   (QUO_W)
    ) u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  (num_y),
        .den  ({sh_reg, 1'b0}),
        .quo  (qy)
    );

    side_t dv_reg [DIV_LAT];

    // clamp and linear texel index
    logic [TEX_DIM_W-1:0] tw_m1;
    logic [TEX_DIM_W-1:0] th_m1;
    logic [TEX_DIM_W-1:0] tx;
    logic [TEX_DIM_W-1:0] ty;
    logic [LIN_W-1:0]     sa_lin_next;

    always_comb begin
        tw_m1 = tw_reg - TEX_DIM_W'(1);
        th_m1 = th_reg - TEX_DIM_W'(1);
        tx = (qx > {1'b0, tw_m1}) ? tw_m1 : qx[TEX_DIM_W-1:0];
        ty = (qy > {1'b0, th_m1}) ? th_m1 : qy[TEX_DIM_W-1:0];
        sa_lin_next = LIN_W'(ty) * LIN_W'(tw_reg) + LIN_W'(tx);
    end

    side_t            sa_reg;
    logic [LIN_W-1:0] sa_lin_reg;

    // wrap into the store
    logic [MOD_W-1:0]  md;
    logic [ADDR_W-1:0] sb_addr_next;

    always_comb begin
        md = MOD_W'(sa_lin_reg);
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            if (md >= (MOD_W'(TEX_WORDS) << k)) begin
                md = md - (MOD_W'(TEX_WORDS) << k);
            end
        end
        sb_addr_next = sa_reg.load ? sa_reg.taddr[ADDR_W-1:0] : md[ADDR_W-1:0];
    end

    side_t             sb_reg;
    logic [ADDR_W-1:0] sb_addr_reg;
    side_t             sc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s1_reg.load  <= 1'b0;
            s1_reg.draw  <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) begin
                dv_reg[i].valid <= 1'b0;
                dv_reg[i].load  <= 1'b0;
                dv_reg[i].draw  <= 1'b0;
            end
            sa_reg.valid <= 1'b0;
            sa_reg.load  <= 1'b0;
            sa_reg.draw  <= 1'b0;
            sb_reg.valid <= 1'b0;
            sb_reg.load  <= 1'b0;
            sb_reg.draw  <= 1'b0;
            sc_reg.valid <= 1'b0;
            sc_reg.load  <= 1'b0;
            sc_reg.draw  <= 1'b0;
        end else if (en) begin
            s1_reg    <= s1_next;
            s1_nx_reg <= s1_nx_next;
            s1_ny_reg <= s1_ny_next;
            dv_reg[0] <= s1_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                dv_reg[i] <= dv_reg[i-1];
            end
            sa_reg      <= dv_reg[DIV_LAT-1];
            sa_lin_reg  <= sa_lin_next;
            sb_reg      <= sa_reg;
            sb_addr_reg <= sb_addr_next;
            sc_reg      <= sb_reg;
        end
    end

    // texture store, written and read at the same stage to keep beat order
    logic [COLOR_W-1:0] texel;

    sctm_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (TEX_WORDS)
    ) u_tex_ram (
        .aclk  (aclk),
        .we    (en && sb_reg.valid && sb_reg.load),
        .waddr (sb_addr_reg),
        .wdata (sb_reg.tval),
        .re    (en),
        .raddr (sb_addr_reg),
        .rdata (texel)
    );

    // key test and output register with skid entry
    logic      cand_valid;
    out_beat_t cand_beat;

    always_comb begin
        cand_valid            = sc_reg.valid && sc_reg.draw && (texel != key_reg);
        cand_beat.pixel_x     = sc_reg.px;
        cand_beat.pixel_y     = sc_reg.py;
        cand_beat.pixel_color = texel;
    end

    logic      m_valid_reg;
    out_beat_t m_beat_reg;
    out_beat_t skid_beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_valid_reg && !m_ready) begin
            if (en && cand_valid) begin
                skid_valid_reg <= 1'b1;
                skid_beat_reg  <= cand_beat;
            end
        end else if (skid_valid_reg) begin
            m_valid_reg    <= 1'b1;
            m_beat_reg     <= skid_beat_reg;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= cand_valid;
            m_beat_reg  <= cand_beat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

    // skid entry only holds a beat behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry full while output register empty");

    // a result arriving at a stalled output goes into the skid entry
    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && cand_valid && m_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("result lost at stalled output");

    // frozen pipeline holds its last stage
    a_frozen_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(sc_reg))
        else $error("last stage moved while pipeline frozen");

    // a drained skid entry always refills the output register
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_ready) |=> (m_valid_reg && !skid_valid_reg))
        else $error("skid beat not moved to output");

endmodule

### tb/sprite_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_pixel_checker
// Watches the register port and both beat channels of the sprite column
// texel mapper. Keeps its own texture store and register copy, works out the
// pixel that each accepted draw beat should give, and compares the output
// beats in order, field by field, counting every mismatch.
// ----------------------------------------------------------------------------
module sprite_pixel_checker #(
    parameter int SCREEN_WIDTH  = sctm_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = sctm_pkg::SCREEN_HEIGHT_DEF,
    parameter int TEX_WORDS     = sctm_pkg::TEX_WORDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sctm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sctm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  sctm_pkg::in_beat_t              s_beat,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  sctm_pkg::out_beat_t             m_beat,
    output int                              pixels_pending,
    output int                              pixels_checked,
    output int                              mismatch_count
);
    import sctm_pkg::*;

    // unit and half unit in signed fixed point with 8 fraction bits
    localparam longint FRAC_ONE = 256;
    localparam longint HALF_ONE = 128;

    logic [23:0]        texel_words [0:TEX_WORDS-1];
    logic [12:0]        spr_height;
    logic [12:0]        spr_width;
    logic signed [12:0] spr_left;
    logic signed [15:0] spr_depth;
    logic [6:0]         tex_w;
    logic [6:0]         tex_h;
    logic [23:0]        key_rgb;
    out_beat_t          pixel_fifo [$];

    function automatic longint clamp_index(input longint v, input longint size);
        if (v < 0)
            return 0;
        if (v >= size)
            return size - 1;
        return v;
    endfunction

    function automatic bit map_pixel(input in_beat_t b, output out_beat_t px);
        longint      col;
        longint      rw;
        longint      sh;
        longint      sw;
        longint      tw;
        longint      th;
        longint      d;
        longint      tx;
        longint      ty;
        longint      addr;
        logic [23:0] texel;
        col = b.column;
        rw  = b.row;
        px  = '0;
        if (col < 0 || col >= SCREEN_WIDTH || rw >= SCREEN_HEIGHT)
            return 1'b0;
        if (spr_depth <= 0 || spr_depth >= b.column_depth)
            return 1'b0;
        // zero sizes behave as one
        sh = (spr_height == 0) ? 1 : spr_height;
        sw = (spr_width == 0) ? 1 : spr_width;
        tw = (tex_w == 0) ? 1 : tex_w;
        th = (tex_h == 0) ? 1 : tex_h;
        tx = clamp_index((col - spr_left) * tw / sw, tw);
        d  = rw * FRAC_ONE - SCREEN_HEIGHT * HALF_ONE + sh * HALF_ONE;
        ty = clamp_index((d * th / sh) / FRAC_ONE, th);
        addr  = (ty * tw + tx) % TEX_WORDS;
        texel = texel_words[addr];
        if (texel == key_rgb)
            return 1'b0;
        px.pixel_x     = col[9:0];
        px.pixel_y     = rw[9:0];
        px.pixel_color = texel;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [43:0] got,
                                   input logic [43:0] want);
        $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : watch
        out_beat_t want;
        if (!aresetn) begin
            spr_height = 13'd1;
            spr_width  = 13'd1;
            spr_left   = '0;
            spr_depth  = '0;
            tex_w      = 7'd64;
            tex_h      = 7'd64;
            key_rgb    = '0;
            pixel_fifo.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SPRITE_HEIGHT: spr_height = cfg_wdata[12:0];
                    CFG_SPRITE_WIDTH:  spr_width  = cfg_wdata[12:0];
                    CFG_SPRITE_LEFT:   spr_left   = cfg_wdata[12:0];
                    CFG_SPRITE_DEPTH:  spr_depth  = cfg_wdata[15:0];
                    CFG_TEX_WIDTH:     tex_w      = cfg_wdata[6:0];
                    CFG_TEX_HEIGHT:    tex_h      = cfg_wdata[6:0];
                    CFG_KEY_COLOR:     key_rgb    = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pixel_fifo.size() == 0) begin
                    report_mismatch("unexpected beat", m_beat, '0);
                end else begin
                    want = pixel_fifo.pop_front();
                    if (m_beat.pixel_x !== want.pixel_x)
                        report_mismatch("pixel_x", m_beat.pixel_x, want.pixel_x);
                    if (m_beat.pixel_y !== want.pixel_y)
                        report_mismatch("pixel_y", m_beat.pixel_y, want.pixel_y);
                    if (m_beat.pixel_color !== want.pixel_color)
                        report_mismatch("pixel_color", m_beat.pixel_color,
                                        want.pixel_color);
                    pixels_checked++;
                end
            end
            if (s_valid && s_ready) begin
                if (s_beat.command == CMD_LOAD) begin
                    if (s_beat.texel_address < TEX_WORDS)
                        texel_words[s_beat.texel_address] = s_beat.texel_value;
                end else if (map_pixel(s_beat, want)) begin
                    pixel_fifo.push_back(want);
                end
            end
        end
        pixels_pending = pixel_fifo.size();
    end

endmodule

### tb/sprite_column_texel_mapper_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_column_texel_mapper_top_tb
// Drives texel loads and pixel draws into the sprite texel mapper under a
// series of sprite and texture settings, first a short directed walk over
// the corner cases, then random phases aimed mostly at the sprite footprint.
// Both channels idle at random; one phase stalls the output for a long
// stretch. The checker beside the block predicts and compares the pixels.
// ----------------------------------------------------------------------------
module sprite_column_texel_mapper_top_tb;
    import sctm_pkg::*;

    localparam int GAP_MAX        = 18;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_BEATS    = 88;
    localparam int PRESSURE_PHASE = 2;
    localparam int FOOTPRINT_MAX  = 256;
    localparam int CENTER_ROW     = SCREEN_HEIGHT_DEF / 2;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_beat_t              s_beat    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_beat_t             m_beat;

    int pixels_pending;
    int pixels_checked;
    int mismatch_count;

    bit send_idle    = 1'b0;
    bit recv_idle    = 1'b0;
    int holds_asked  = 0;
    int holds_served = 0;
    int loaded_words = 0;
    int loads_sent   = 0;
    int draws_sent   = 0;
    int settings_run = 0;

    // current settings, kept to aim the draws
    int          cur_h     = 1;
    int          cur_w     = 1;
    int          cur_left  = 0;
    int          cur_depth = 0;
    int          cur_tw    = 64;
    int          cur_th    = 64;
    logic [23:0] cur_key   = '0;

    sprite_column_texel_mapper_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_beat    (s_beat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_beat    (m_beat)
    );

    sprite_pixel_checker pixel_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_beat         (s_beat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_beat         (m_beat),
        .pixels_pending (pixels_pending),
        .pixels_checked (pixels_checked),
        .mismatch_count (mismatch_count)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // output side: random stall per beat, one long hold when asked
    initial begin : sink
        int stall;
        forever begin
            @(negedge aclk);
            if (holds_served != holds_asked) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                stall = recv_idle ? $urandom_range(0, GAP_MAX) : 0;
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
                m_ready <= 1'b1;
            end
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
        end
    end

    function automatic int fit(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int footprint();
        return (cur_tw == 0 ? 1 : cur_tw) * (cur_th == 0 ? 1 : cur_th);
    endfunction

    function automatic logic [23:0] pick_color();
        if ($urandom_range(0, 5) == 0)
            return cur_key;
        return 24'($urandom);
    endfunction

    function automatic in_beat_t load_beat(input int addr, input logic [23:0] rgb);
        in_beat_t b;
        b.column        = 12'($urandom);
        b.row           = 10'($urandom);
        b.column_depth  = 16'($urandom);
        b.command       = CMD_LOAD;
        b.texel_address = 12'(addr);
        b.texel_value   = rgb;
        return b;
    endfunction

    function automatic in_beat_t draw_beat(input int col, input int rw, input int wall);
        in_beat_t b;
        b.command       = CMD_DRAW;
        b.texel_address = 12'($urandom);
        b.texel_value   = 24'($urandom);
        b.column        = 12'(col);
        b.row           = 10'(rw);
        b.column_depth  = 16'(wall);
        return b;
    endfunction

    task automatic send_beat(input in_beat_t b);
        int gap;
        gap = send_idle ? $urandom_range(0, GAP_MAX) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_beat  <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (b.command == CMD_LOAD)
            loads_sent++;
        else
            draws_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pixels_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_sprite(input int h, input int w, input int left, input int depth,
                              input int tw, input int th, input logic [23:0] key);
        drain();
        put_reg(CFG_SPRITE_HEIGHT, h);
        put_reg(CFG_SPRITE_WIDTH, w);
        put_reg(CFG_SPRITE_LEFT, left);
        put_reg(CFG_SPRITE_DEPTH, depth);
        put_reg(CFG_TEX_WIDTH, tw);
        put_reg(CFG_TEX_HEIGHT, th);
        put_reg(CFG_KEY_COLOR, int'(key));
        cur_h     = h;
        cur_w     = w;
        cur_left  = left;
        cur_depth = depth;
        cur_tw    = tw;
        cur_th    = th;
        cur_key   = key;
        settings_run++;
    endtask

    // every word the texture can reach is written before any draw reads it
    task automatic fill_texture();
        for (int a = loaded_words; a < footprint(); a++)
            send_beat(load_beat(a, pick_color()));
        if (footprint() > loaded_words)
            loaded_words = footprint();
    endtask

    task automatic random_settings(input bit visible);
        int h;
        int w;
        int left;
        int depth;
        int tw;
        int th;
        case ($urandom_range(0, 5))
            0: h = 1;
            1: h = 4096;
            2: h = $urandom_range(0, 4096);
            default: h = $urandom_range(1, 96);
        endcase
        case ($urandom_range(0, 5))
            0: w = 1;
            1: w = 4096;
            2: w = $urandom_range(0, 4096);
            default: w = $urandom_range(1, 96);
        endcase
        case ($urandom_range(0, 7))
            0: left = -4096;
            1: left = 4095;
            2: left = $urandom_range(0, 8191) - 4096;
            default: left = $urandom_range(0, 1000) - 40;
        endcase
        case (visible ? 2 : $urandom_range(0, 7))
            0: depth = $urandom_range(0, 65535) - 32768;
            1: depth = 0;
            default: depth = $urandom_range(1, 20000);
        endcase
        if ($urandom_range(0, 1)) begin
            tw = $urandom_range(0, 64);
            th = fit($urandom_range(0, FOOTPRINT_MAX / (tw == 0 ? 1 : tw)), 0, 64);
        end else begin
            th = $urandom_range(0, 64);
            tw = fit($urandom_range(0, FOOTPRINT_MAX / (th == 0 ? 1 : th)), 0, 64);
        end
        set_sprite(h, w, left, depth, tw, th,
                   $urandom_range(0, 3) == 0 ? 24'hFFFFFF : 24'($urandom));
    endtask

    function automatic in_beat_t random_beat();
        int col;
        int rw;
        int wall;
        int lo;
        int hi;
        int sh;
        if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1))
                return load_beat($urandom_range(0, footprint() - 1), pick_color());
            return load_beat($urandom_range(0, TEX_WORDS_DEF - 1), pick_color());
        end
        lo = fit(cur_left, 0, SCREEN_WIDTH_DEF - 1);
        hi = fit(cur_left + (cur_w == 0 ? 1 : cur_w) - 1, -1, SCREEN_WIDTH_DEF - 1);
        case ($urandom_range(0, 9))
            0: col = $urandom_range(0, 4095) - 2048;
            1: begin
                case ($urandom_range(0, 3))
                    0: col = -1;
                    1: col = 0;
                    2: col = SCREEN_WIDTH_DEF - 1;
                    default: col = SCREEN_WIDTH_DEF;
                endcase
            end
            default: col = (lo <= hi) ? $urandom_range(lo, hi)
                                      : $urandom_range(0, SCREEN_WIDTH_DEF - 1);
        endcase
        sh = (cur_h == 0) ? 1 : cur_h;
        case ($urandom_range(0, 9))
            0: rw = $urandom_range(0, 1023);
            1, 2: rw = $urandom_range(0, SCREEN_HEIGHT_DEF - 1);
            default: rw = fit(CENTER_ROW - sh / 2 + $urandom_range(0, sh - 1),
                              0, SCREEN_HEIGHT_DEF - 1);
        endcase
        case ($urandom_range(0, 9))
            0: wall = $urandom_range(0, 65535) - 32768;
            1: wall = cur_depth;
            default: wall = (cur_depth < 32767)
                          ? cur_depth + 1 + $urandom_range(0, 32766 - cur_depth) : 32767;
        endcase
        return draw_beat(col, rw, wall);
    endfunction

    initial begin : stimulus
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        send_idle = 1'b1;
        recv_idle = 1'b1;

        // reset settings: sprite depth zero turns every draw away
        send_beat(load_beat(TEX_WORDS_DEF - 1, 24'hFFFFFF));
        send_beat(load_beat(0, 24'h000000));
        send_beat(draw_beat(0, 0, 32767));

        // zero sizes act as one: a single-texel sprite
        set_sprite(0, 0, 0, 1, 0, 0, 24'hFFFFFF);
        fill_texture();
        send_beat(load_beat(0, 24'h000000));
        send_beat(draw_beat(0, 0, 2));
        send_beat(draw_beat(SCREEN_WIDTH_DEF - 1, SCREEN_HEIGHT_DEF - 1, 32767));
        send_beat(draw_beat(-1, 10, 100));
        send_beat(draw_beat(SCREEN_WIDTH_DEF, 10, 100));
        send_beat(draw_beat(-2048, 10, 100));
        send_beat(draw_beat(2047, 10, 100));
        send_beat(draw_beat(10, SCREEN_HEIGHT_DEF, 100));
        send_beat(draw_beat(10, 1023, 100));
        send_beat(draw_beat(10, 10, 1));
        send_beat(draw_beat(10, 10, -32768));
        send_beat(load_beat(0, 24'hFFFFFF));
        send_beat(draw_beat(5, 5, 100));

        // extreme sprite, wide flat texture, depth behind the camera
        set_sprite(4096, 4096, -4096, -32768, 64, 4, 24'h000000);
        fill_texture();
        send_beat(draw_beat(0, 0, 0));
        drain();
        put_reg(CFG_SPRITE_DEPTH, 32767);
        cur_depth = 32767;
        send_beat(draw_beat(SCREEN_WIDTH_DEF - 1, CENTER_ROW, 32767));
        send_beat(draw_beat(500, CENTER_ROW, 32767));

        // narrow tall texture, sprite starting right of the screen
        set_sprite(1, 1, 4095, 1, 4, 64, 24'h000000);
        fill_texture();
        send_beat(draw_beat(1000, CENTER_ROW, 5));
        send_beat(draw_beat(0, 0, 5));

        for (int p = 0; p < RAND_PHASES; p++) begin
            random_settings(p == PRESSURE_PHASE);
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            fill_texture();
            if (p == PRESSURE_PHASE) begin
                send_idle = 1'b0;
                holds_asked++;
            end
            repeat (PHASE_BEATS) send_beat(random_beat());
        end
        drain();

        $display("%0d beats in (%0d texel loads, %0d draws), %0d pixels out checked",
                 loads_sent + draws_sent, loads_sent, draws_sent, pixels_checked);
        $display("%0d sprite settings incl. zero sizes and extremes, %0d long output hold",
                 settings_run, holds_served);
        if (mismatch_count == 0 && pixels_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
